FILE: src/swbd_pkg.sv
// Shared constants for the sliding window burst detector.
// Register map, reset values and result field layout; no dependencies.
package swbd_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_WINDOW_TICKS = 2'd0;
  localparam logic [1:0] REG_ENTER_COUNT  = 2'd1;
  localparam logic [1:0] REG_EXIT_COUNT   = 2'd2;

  localparam int TICKS_W = 32;
  localparam int THR_W   = 9;
  localparam int TIME_W  = 48;
  localparam int TOTAL_W = 32;

  localparam logic [TICKS_W-1:0] WINDOW_TICKS_RST = 32'd1000000;
  localparam logic [THR_W-1:0]   ENTER_COUNT_RST  = 9'd64;
  localparam logic [THR_W-1:0]   EXIT_COUNT_RST   = 9'd48;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  typedef struct packed {
    logic [TOTAL_W-1:0] burst_total;
    logic [TOTAL_W-1:0] total_events;
    logic               ring_overflow;
    logic               burst_end;
    logic               burst_start;
    logic               burst_active;
    logic [THR_W-1:0]   window_count;
  } result_t;

endpackage

FILE: src/swbd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module swbd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/sliding_window_burst_detector.sv
// Sliding window burst detector top level with its APB register file.
// Depends on swbd_pkg and on swbd_ram for the timestamp ring.
//
// Each transfer on the input stream either records an event with its timestamp
// or clears the window, and produces exactly one result transfer. A recorded
// event is written to the ring RAM, and the eviction loop then reads one head
// stamp per cycle from the ring RAM and compares it with the new timestamp,
// dropping head stamps while they fall out of the window.
// A new input transfer is taken while the previous result still waits on the
// output register; the block stalls only when a second result is ready before
// the first one has been taken.
module sliding_window_burst_detector
  import swbd_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int STAMP_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata: event_time[47:0]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: action[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: window_count[8:0], burst_active[9], burst_start[10], burst_end[11],
  // ring_overflow[12], total_events[44:13], burst_total[76:45], zero[79:77]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int DIF_W = (STAMP_BITS > TICKS_W) ? STAMP_BITS : TICKS_W;
  localparam int RES_W = $bits(result_t);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVICT  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic                  burst_r, burst_nxt;
  logic [TOTAL_W-1:0]    ev_total_r, ev_total_nxt;
  logic [TOTAL_W-1:0]    bu_total_r, bu_total_nxt;
  logic [STAMP_BITS-1:0] now_r, now_nxt;
  logic                  clear_r, clear_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r, out_res_nxt;

  logic [TICKS_W-1:0]    window_r;
  logic [THR_W-1:0]      enter_r;
  logic [THR_W-1:0]      exit_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [STAMP_BITS-1:0] ram_rdata;

  logic                  in_fire;
  logic                  out_free;
  logic                  ring_full;
  logic [SUM_W-1:0]      tail_sum;
  logic [AW-1:0]         tail_idx;
  logic [AW-1:0]         head_inc;
  logic [STAMP_BITS-1:0] in_stamp;
  logic [DIF_W-1:0]      age;
  logic                  too_old;
  logic                  fin_start;
  logic                  fin_end;
  logic [TOTAL_W-1:0]    fin_bu_total;
  logic                  cfg_wr;

  swbd_ram #(
    .WIDTH(STAMP_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(now_nxt),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_TICKS_RST;
      enter_r  <= ENTER_COUNT_RST;
      exit_r   <= EXIT_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_WINDOW_TICKS: window_r <= cfg_pwdata;
        REG_ENTER_COUNT:  enter_r  <= cfg_pwdata[THR_W-1:0];
        REG_EXIT_COUNT:   exit_r   <= cfg_pwdata[THR_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_WINDOW_TICKS: cfg_prdata = window_r;
      REG_ENTER_COUNT:  cfg_prdata = {{(CFG_DATA_W-THR_W){1'b0}}, enter_r};
      REG_EXIT_COUNT:   cfg_prdata = {{(CFG_DATA_W-THR_W){1'b0}}, exit_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_res_r};

  assign in_stamp  = STAMP_BITS'(in_tdata);
  assign ring_full = (live_r == CNT_W'(RING_DEPTH));
  assign head_inc  = (head_r == AW'(RING_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(live_r);
  assign tail_idx  = (tail_sum >= SUM_W'(RING_DEPTH)) ?
                     AW'(tail_sum - SUM_W'(RING_DEPTH)) : AW'(tail_sum);

  assign age     = DIF_W'(now_r) - DIF_W'(ram_rdata);
  assign too_old = (now_r > ram_rdata) && (age > DIF_W'(window_r));

  assign fin_start = !clear_r && !burst_r &&
                     (CMP_W'(live_r) >= CMP_W'(enter_r));
  assign fin_end   = !clear_r && burst_r &&
                     (CMP_W'(live_r) < CMP_W'(exit_r));
  assign fin_bu_total = (fin_start && (bu_total_r != '1)) ?
                        bu_total_r + TOTAL_W'(1) : bu_total_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    live_nxt      = live_r;
    burst_nxt     = burst_r;
    ev_total_nxt  = ev_total_r;
    bu_total_nxt  = bu_total_r;
    now_nxt       = now_r;
    clear_nxt     = clear_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_idx;
    ram_re        = 1'b0;
    ram_raddr     = head_inc;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          now_nxt   = in_stamp;
          clear_nxt = in_tuser;
          ovf_nxt   = 1'b0;
          if (in_tuser) begin
            head_nxt  = '0;
            live_nxt  = '0;
            burst_nxt = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            if (ev_total_r != '1) begin
              ev_total_nxt = ev_total_r + TOTAL_W'(1);
            end
            ram_we = 1'b1;
            if (ring_full) begin
              ram_waddr = head_r;
              head_nxt  = head_inc;
              ovf_nxt   = 1'b1;
            end else begin
              live_nxt = live_r + CNT_W'(1);
            end
            ram_raddr = ring_full ? head_inc : head_r;
            if (live_nxt > CNT_W'(1)) begin
              ram_re    = 1'b1;
              state_nxt = ST_EVICT;
            end else begin
              state_nxt = ST_FINISH;
            end
          end
        end
      end
      ST_EVICT: begin
        if (too_old && (live_r > CNT_W'(1))) begin
          head_nxt = head_inc;
          live_nxt = live_r - CNT_W'(1);
          if (live_nxt > CNT_W'(1)) begin
            ram_re = 1'b1;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if ((state_r != ST_IDLE) && (state_nxt == ST_IDLE)) begin
      burst_nxt                 = (burst_r || fin_start) && !fin_end;
      bu_total_nxt              = fin_bu_total;
      out_valid_nxt             = 1'b1;
      out_res_nxt.window_count  = THR_W'(live_r);
      out_res_nxt.burst_active  = (burst_r || fin_start) && !fin_end;
      out_res_nxt.burst_start   = fin_start;
      out_res_nxt.burst_end     = fin_end;
      out_res_nxt.ring_overflow = ovf_r;
      out_res_nxt.total_events  = ev_total_r;
      out_res_nxt.burst_total   = fin_bu_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      live_r      <= '0;
      burst_r     <= 1'b0;
      ev_total_r  <= '0;
      bu_total_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      live_r      <= live_nxt;
      burst_r     <= burst_nxt;
      ev_total_r  <= ev_total_nxt;
      bu_total_r  <= bu_total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    clear_r   <= clear_nxt;
    ovf_r     <= ovf_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule
